### sv/cog_alu_with_flags_macros.svh
// Assertion macros for the conditional ALU block.
`ifndef COG_ALU_WITH_FLAGS_MACROS_SVH
`define COG_ALU_WITH_FLAGS_MACROS_SVH

`ifndef ASSERT_OFF
`define CAWF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");
`define CAWF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");
`else
`define CAWF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CAWF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/cawf_pkg.sv
`timescale 1ns / 1ps

package cawf_pkg;

	// Operation codes; code 31 is undefined and never executes
	typedef enum logic [4:0] {
		OP_AND   = 5'd0,
		OP_OR    = 5'd1,
		OP_XOR   = 5'd2,
		OP_MOV   = 5'd3,
		OP_NOT   = 5'd4,
		OP_ADD   = 5'd5,
		OP_SUB   = 5'd6,
		OP_SAR   = 5'd7,
		OP_CMP   = 5'd8,
		OP_CMPS  = 5'd9,
		OP_TEST  = 5'd10,
		OP_TESTN = 5'd11,
		OP_NEG   = 5'd12,
		OP_ABS   = 5'd13,
		OP_SHL   = 5'd14,
		OP_SHR   = 5'd15,
		OP_ROL   = 5'd16,
		OP_ROR   = 5'd17,
		OP_ADDX  = 5'd18,
		OP_SUBX  = 5'd19,
		OP_ADDS  = 5'd20,
		OP_SUBS  = 5'd21,
		OP_FGE   = 5'd22,
		OP_FLE   = 5'd23,
		OP_DECOD = 5'd24,
		OP_ENCOD = 5'd25,
		OP_ONES  = 5'd26,
		OP_MUXC  = 5'd27,
		OP_MUXNC = 5'd28,
		OP_MUXZ  = 5'd29,
		OP_MUXNZ = 5'd30
	} op_t;

	// Condition codes that always execute
	localparam logic [3:0] CC_ALWAYS_LO = 4'h0;
	localparam logic [3:0] CC_ALWAYS_HI = 4'hF;

	localparam int unsigned DATA_W = 32;

	typedef struct packed {
		logic [4:0]        mode;
		logic [3:0]        cond_code;
		logic [DATA_W-1:0] d_value;
		logic [DATA_W-1:0] s_value;
		logic              write_c;
		logic              write_z;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] result_value;
		logic              d_write;
		logic              executed;
		logic              carry_out;
		logic              zero_out;
	} rsp_t;

	// Population count as a five-level adder tree
	function automatic logic [5:0] pop32(input logic [31:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++) begin
			l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		return {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

	// Index of the highest set bit by halving search; zero input gives 0
	function automatic logic [4:0] top_index(input logic [31:0] v);
		logic [31:0] w;
		logic [4:0]  idx;
		w   = v;
		idx = '0;
		if (w[31:16] != '0) begin
			idx[4] = 1'b1;
			w      = w >> 16;
		end
		if (w[15:8] != '0) begin
			idx[3] = 1'b1;
			w      = w >> 8;
		end
		if (w[7:4] != '0) begin
			idx[2] = 1'b1;
			w      = w >> 4;
		end
		if (w[3:2] != '0) begin
			idx[1] = 1'b1;
			w      = w >> 2;
		end
		idx[0] = w[1];
		return idx;
	endfunction

endpackage

### sv/cawf_if.sv
`timescale 1ns / 1ps

// Instruction channel
interface cawf_cmd_if;
	logic               valid;
	logic               ready;
	cawf_pkg::cmd_t     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface cawf_rsp_if;
	logic               valid;
	logic               ready;
	cawf_pkg::rsp_t     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### sv/cog_alu_with_flags.sv
`timescale 1ns / 1ps
// An accepted item passes the input register, then the result register that drives rsp.
// Throughput: one item per cycle while rsp does not stall; the C/Z flags close a loop from the
// flag registers through the condition check and flag update back to the registers.
// Reset (arst_n low, asynchronous): both flags cleared, input and result stages emptied.
`include "cog_alu_with_flags_macros.svh"

module cog_alu_with_flags (
	input  logic            clk,
	input  logic            arst_n,
	cawf_cmd_if.sink        cmd,
	cawf_rsp_if.source      rsp
);

	cawf_pkg::cmd_t item_s1;
	logic           valid_s1;
	cawf_pkg::rsp_t res_q;
	logic           valid_q;
	logic           carry_q;
	logic           zero_q;

	logic           advance;
	cawf_pkg::rsp_t res_d;
	logic           carry_d;
	logic           zero_d;

	// Handshake: stage 1 moves when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign rsp.valid = valid_q;
	assign rsp.data  = res_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	// Result register and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			carry_q <= 1'b0;
			zero_q  <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
			carry_q <= carry_d;
			zero_q  <= zero_d;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// Execute: condition, operation, flag rules
	always_comb begin
		cawf_pkg::op_t op;
		logic [31:0]   d;
		logic [31:0]   s;
		logic [4:0]    n;
		logic [4:0]    m;
		logic          run;
		logic          cin;
		logic [32:0]   sum_w;
		logic [32:0]   dif_w;
		logic [32:0]   ssum_w;
		logic [32:0]   sdif_w;
		logic [63:0]   rol_w;
		logic [63:0]   ror_w;
		logic          lprobe;
		logic          rprobe;
		logic          mux_f;
		logic [31:0]   r;
		logic          c;
		logic          wr;
		logic          sticky;
		logic          cvalid;
		logic          z;

		op  = cawf_pkg::op_t'(item_s1.mode);
		d   = item_s1.d_value;
		s   = item_s1.s_value;
		n   = s[4:0];
		m   = (n == 5'd0) ? 5'd0 : n - 5'd1;

		// Condition against the flags held before this item
		run = (item_s1.cond_code == cawf_pkg::CC_ALWAYS_LO)
		   || (item_s1.cond_code == cawf_pkg::CC_ALWAYS_HI)
		   || item_s1.cond_code[{carry_q, zero_q}];

		// Shared arithmetic; old carry enters only the extended forms
		cin    = ((op == cawf_pkg::OP_ADDX) || (op == cawf_pkg::OP_SUBX)) && carry_q;
		sum_w  = {1'b0, d} + {1'b0, s} + {32'd0, cin};
		dif_w  = {1'b0, d} - {1'b0, s} - {32'd0, cin};
		ssum_w = {d[31], d} + {s[31], s};
		sdif_w = {d[31], d} - {s[31], s};
		rol_w  = {d, d} << n;
		ror_w  = {d, d} >> n;
		lprobe = d[5'd31 - m];
		rprobe = d[m];
		mux_f  = ((op == cawf_pkg::OP_MUXC) || (op == cawf_pkg::OP_MUXNC)) ? carry_q : zero_q;
		if ((op == cawf_pkg::OP_MUXNC) || (op == cawf_pkg::OP_MUXNZ)) begin
			mux_f = !mux_f;
		end

		r      = d;
		c      = carry_q;
		wr     = 1'b1;
		sticky = 1'b0;
		cvalid = 1'b1;

		unique case (op)
			cawf_pkg::OP_AND:   begin r = d & s;  c = ^r; end
			cawf_pkg::OP_OR:    begin r = d | s;  c = ^r; end
			cawf_pkg::OP_XOR:   begin r = d ^ s;  c = ^r; end
			cawf_pkg::OP_MOV:   begin r = s;      c = r[31]; end
			cawf_pkg::OP_NOT:   begin r = ~s;     c = r[31]; end
			cawf_pkg::OP_ADD:   begin r = sum_w[31:0]; c = sum_w[32]; end
			cawf_pkg::OP_SUB:   begin r = dif_w[31:0]; c = dif_w[32]; end
			cawf_pkg::OP_SAR:   begin r = 32'($signed(d) >>> n); c = rprobe; end
			cawf_pkg::OP_CMP:   begin r = dif_w[31:0]; c = dif_w[32]; wr = 1'b0; end
			cawf_pkg::OP_CMPS:  begin r = dif_w[31:0]; c = sdif_w[32]; wr = 1'b0; end
			cawf_pkg::OP_TEST:  begin r = d & s;  c = ^r; wr = 1'b0; end
			cawf_pkg::OP_TESTN: begin r = d & ~s; c = ^r; wr = 1'b0; end
			cawf_pkg::OP_NEG:   begin r = 32'd0 - s; c = r[31]; end
			cawf_pkg::OP_ABS:   begin r = s[31] ? 32'd0 - s : s; c = s[31]; end
			cawf_pkg::OP_SHL:   begin r = d << n; c = lprobe; end
			cawf_pkg::OP_SHR:   begin r = d >> n; c = rprobe; end
			cawf_pkg::OP_ROL:   begin r = rol_w[63:32]; c = lprobe; end
			cawf_pkg::OP_ROR:   begin r = ror_w[31:0];  c = rprobe; end
			cawf_pkg::OP_ADDX:  begin r = sum_w[31:0]; c = sum_w[32]; sticky = 1'b1; end
			cawf_pkg::OP_SUBX:  begin r = dif_w[31:0]; c = dif_w[32]; sticky = 1'b1; end
			cawf_pkg::OP_ADDS:  begin r = sum_w[31:0]; c = ssum_w[32]; end
			cawf_pkg::OP_SUBS:  begin r = dif_w[31:0]; c = sdif_w[32]; end
			cawf_pkg::OP_FGE:   begin c = dif_w[32]; r = c ? s : d; end
			cawf_pkg::OP_FLE:   begin c = (s < d); r = c ? s : d; end
			cawf_pkg::OP_DECOD: begin r = 32'd1 << n; cvalid = 1'b0; end
			cawf_pkg::OP_ENCOD: begin r = {27'd0, cawf_pkg::top_index(s)}; c = (s != 32'd0); end
			cawf_pkg::OP_ONES:  begin r = {26'd0, cawf_pkg::pop32(s)}; c = r[0]; end
			cawf_pkg::OP_MUXC,
			cawf_pkg::OP_MUXNC,
			cawf_pkg::OP_MUXZ,
			cawf_pkg::OP_MUXNZ: begin r = (d & ~s) | ({32{mux_f}} & s); c = ^r; end
			default:            begin run = 1'b0; end
		endcase

		z = (r == 32'd0) && (!sticky || zero_q);

		// Skipped items leave D and both flags untouched
		carry_d = (run && item_s1.write_c && cvalid) ? c : carry_q;
		zero_d  = (run && item_s1.write_z) ? z : zero_q;

		res_d.result_value = (run && wr) ? r : d;
		res_d.d_write      = run && wr;
		res_d.executed     = run;
		res_d.carry_out    = carry_d;
		res_d.zero_out     = zero_d;
	end

	// Checks
	`CAWF_ASSERT_NEXT(a_flags_hold_on_stall, clk, arst_n, valid_q && !rsp.ready, $stable(carry_q) && $stable(zero_q))
	`CAWF_ASSERT_IMPL(a_flags_match_result, clk, arst_n, valid_q, (res_q.carry_out == carry_q) && (res_q.zero_out == zero_q))
	`CAWF_ASSERT_IMPL(a_skip_no_write, clk, arst_n, valid_q && !res_q.executed, !res_q.d_write)
	`CAWF_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, !cmd.ready, valid_s1 && valid_q)

endmodule
